// ===== design/fssm_pkg.sv =====
package fssm_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_SEARCHING = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic append;
    logic text_start;
    logic cmp_start;
    logic cmp_step;
    logic out_load;
  } fssm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic append_ok;
    logic text_empty;
    logic text_end;
    logic searching;
    logic cmp_done;
  } fssm_sts_t;

endpackage

// ===== design/fssm_datapath.sv =====
module fssm_datapath import fssm_pkg::*; #(
  parameter int MAX_LEN = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fssm_cmd_t  cmd_i,
  output fssm_sts_t  sts_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] byte_value_i,
  output logic [1:0] status_o,
  output logic [6:0] match_index_o
);
  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  logic [7:0]    pat_mem [MAX_LEN];
  logic [7:0]    txt_mem [MAX_LEN];
  logic [LW-1:0] plen_q, tpos_q, k_q, start_q;
  status_e       stat_q;
  logic [6:0]    fidx_q;
  logic [7:0]    pat_rd_q, txt_rd_q;
  logic          rd_vld_q, mism_q;
  logic [1:0]    status_q;
  logic [6:0]    mi_q;
  logic [LW-1:0] tpos_n, start_n;
  logic          hit;

  assign tpos_n  = tpos_q + LW'(1);
  assign start_n = tpos_n - plen_q;

  assign sts_o.searching  = (stat_q == ST_SEARCHING);
  assign sts_o.append_ok  = (stat_q == ST_SEARCHING) && (tpos_q == '0) &&
                            (byte_value_i != 8'd0) && (plen_q < LW'(MAX_LEN));
  assign sts_o.text_empty = (plen_q == '0);
  assign sts_o.text_end   = (byte_value_i == 8'd0) || (tpos_q >= LW'(MAX_LEN));
  // done when the last compared pair has been read
  assign sts_o.cmp_done   = rd_vld_q && (k_q == plen_q);

  // last pair matches and nothing earlier mismatched
  assign hit = cmd_i.cmp_step && sts_o.cmp_done && !mism_q &&
               !(rd_vld_q && pat_rd_q != txt_rd_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) pat_mem[plen_q[AW-1:0]] <= byte_value_i;
    if (cmd_i.text_start) txt_mem[tpos_q[AW-1:0]] <= byte_value_i;
    pat_rd_q <= pat_mem[k_q[AW-1:0]];
    txt_rd_q <= txt_mem[AW'(start_q + k_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0; tpos_q <= '0; stat_q <= ST_SEARCHING; fidx_q <= '0;
      k_q <= '0; start_q <= '0; rd_vld_q <= 1'b0; mism_q <= 1'b0;
      status_q <= '0; mi_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        plen_q <= '0; tpos_q <= '0; stat_q <= ST_SEARCHING; fidx_q <= '0;
      end
      if (cmd_i.append) plen_q <= plen_q + LW'(1);
      if (cmd_i.text_start) begin
        if (plen_q == '0) stat_q <= ST_EMPTY;
        else if (byte_value_i == 8'd0 || tpos_q >= LW'(MAX_LEN)) stat_q <= ST_NOT_FOUND;
        else begin
          tpos_q  <= tpos_n;
          start_q <= start_n;
        end
      end
      if (cmd_i.cmp_start) begin
        k_q <= '0; rd_vld_q <= 1'b0; mism_q <= (tpos_q < plen_q);
      end
      if (cmd_i.cmp_step) begin
        if (rd_vld_q && pat_rd_q != txt_rd_q) mism_q <= 1'b1;
        // the compare at k reads after k advances, so count up to plen
        if (k_q != plen_q) k_q <= k_q + LW'(1);
        rd_vld_q <= 1'b1;
        if (hit) begin
          stat_q <= ST_FOUND;
          fidx_q <= 7'(start_q);
        end
      end
      if (cmd_i.out_load) begin
        // a hit on the last compare step is loaded straight through
        status_q <= hit ? ST_FOUND : stat_q;
        mi_q     <= hit ? 7'(start_q) : ((stat_q == ST_FOUND) ? fidx_q : 7'd0);
      end
    end
  end

  assign status_o      = status_q;
  assign match_index_o = mi_q;

  logic unused;
  assign unused = ^opcode_i;
endmodule

// ===== design/fssm_ctrl.sv =====
module fssm_ctrl import fssm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output fssm_cmd_t  cmd_o,
  input  fssm_sts_t  sts_i
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_FIN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   acc;
  logic   go_cmp;
  logic   cmp_act_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign acc = in_valid_i && (state_q == S_IDLE);
  assign go_cmp = acc && opcode_i == OP_TEXT && sts_i.searching &&
                  !sts_i.text_empty && !sts_i.text_end;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          cmd_o.clear      = (opcode_i == OP_CLEAR);
          cmd_o.append     = (opcode_i == OP_APPEND) && sts_i.append_ok;
          cmd_o.text_start = (opcode_i == OP_TEXT) && sts_i.searching;
          state_d = go_cmp ? S_CMP : S_FIN;
        end
      end
      S_CMP: begin
        cmd_o.cmp_start = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        // compare steps only run for a searched text byte
        cmd_o.cmp_step = cmp_act_q;
        if (sts_i.cmp_done || !cmp_act_q) begin
          cmd_o.out_load = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cmp_act_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CMP) cmp_act_q <= 1'b1;
      else if (state_q == S_OUT) cmp_act_q <= 1'b0;
    end
  end
endmodule

// ===== design/first_substring_match_search.sv =====
// First-occurrence substring search.
// Input channel (in_valid_i / in_stall_o) carries opcode_i and byte_value_i:
// clear, append pattern byte, or text byte. Every input beat yields exactly
// one output beat (out_valid_o / out_stall_i) with status_o and match_index_o.
// Items are handled one at a time. A clear, append or terminal text byte
// goes from S_IDLE through S_FIN to S_OUT, where its result beat is offered.
// A text byte that is searched goes through S_CMP, then compares the whole
// pattern against the window tail in S_FIN, one byte pair per cycle out of
// the pattern and text RAMs, before its result beat is offered in S_OUT.
// The input stalls until the result beat is taken; while out_stall_i is
// high the result holds. Reset clears pattern length, text position and
// status; the RAMs are not cleared and need no sweep.
module first_substring_match_search import fssm_pkg::*; #(
  parameter int MAX_LEN = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] byte_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [6:0] match_index_o
);
  fssm_cmd_t cmd;
  fssm_sts_t sts;

  fssm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i,
    .out_valid_o, .out_stall_i, .cmd_o(cmd), .sts_i(sts)
  );

  fssm_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .opcode_i, .byte_value_i,
    .status_o, .match_index_o
  );

  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_FOUND |-> match_index_o == 7'd0)
    else $error("match index set without found");
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result changed under stall");
endmodule

// ===== bench/first_substring_match_search_tb.sv =====
`timescale 1ns / 100ps

module first_substring_match_search_tb;
  import fssm_pkg::*;

  localparam int MaxLen = 128;

  typedef struct packed {
    opcode_e    op;
    logic [7:0] ch;
  } beat_t;

  typedef struct packed {
    status_e    status;
    logic [6:0] index;
  } verdict_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] opcode_i;
  logic [7:0] byte_value_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] status_o;
  logic [6:0] match_index_o;

  first_substring_match_search #(.MAX_LEN(MaxLen)) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .byte_value_i (byte_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .match_index_o(match_index_o)
  );

  // search predictor state
  logic [7:0] pat_mem [MaxLen];
  logic [7:0] txt_mem [MaxLen];
  int         pat_len;
  int         txt_pos;
  status_e    srch_st;
  logic [6:0] hit_idx;

  beat_t    pending_beats[$];
  verdict_t expected_verdicts[$];
  int       send_idle_pct;
  int       recv_stall_pct;
  bit       hold_off;
  bit       hold_go;
  bit       failed;

  function automatic verdict_t search_step(beat_t b);
    verdict_t v;
    bit       hit;
    case (b.op)
      OP_CLEAR: begin
        pat_len = 0;
        txt_pos = 0;
        srch_st = ST_SEARCHING;
        hit_idx = '0;
      end
      OP_APPEND: begin
        if (srch_st == ST_SEARCHING && txt_pos == 0 && b.ch != 0 && pat_len < MaxLen) begin
          pat_mem[pat_len] = b.ch;
          pat_len++;
        end
      end
      OP_TEXT: begin
        if (srch_st == ST_SEARCHING) begin
          if (pat_len == 0) begin
            srch_st = ST_EMPTY;
          end else if (b.ch == 0 || txt_pos >= MaxLen) begin
            srch_st = ST_NOT_FOUND;
          end else begin
            txt_mem[txt_pos] = b.ch;
            txt_pos++;
            if (txt_pos >= pat_len) begin
              hit = 1'b1;
              for (int k = 0; k < pat_len; k++)
                if (txt_mem[txt_pos - pat_len + k] != pat_mem[k]) hit = 1'b0;
              if (hit) begin
                srch_st = ST_FOUND;
                hit_idx = 7'(txt_pos - pat_len);
              end
            end
          end
        end
      end
      default: ;
    endcase
    v.status = srch_st;
    v.index  = (srch_st == ST_FOUND) ? hit_idx : '0;
    return v;
  endfunction

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // driver
  bit taken;
  always @(posedge clk_i) begin
    taken <= rst_ni && in_valid_i && !in_stall_o;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || taken) begin
      if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        beat_t b;
        b = pending_beats.pop_front();
        expected_verdicts.push_back(search_step(b));
        opcode_i     <= b.op;
        byte_value_i <= b.ch;
        in_valid_i   <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // long receiver hold-off, counted here
  initial begin
    hold_off = 1'b0;
    forever begin
      wait (hold_go);
      hold_off = 1'b1;
      repeat (200) @(posedge clk_i);
      hold_off = 1'b0;
      hold_go  = 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    verdict_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        $error("result beat with nothing expected: status %0d index %0d",
               status_o, match_index_o);
        failed = 1'b1;
      end else begin
        e = expected_verdicts.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          failed = 1'b1;
        end
        if (match_index_o !== e.index) begin
          $error("match_index: expected %0d, got %0d", e.index, match_index_o);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic add(opcode_e op, logic [7:0] ch);
    beat_t b;
    b.op = op;
    b.ch = ch;
    pending_beats.push_back(b);
  endtask

  // pattern then text over a small alphabet so matches happen often
  task automatic add_search(int max_pat, int max_txt);
    logic [7:0] pat[$];
    int         plen;
    int         tlen;
    int         alpha;
    plen  = $urandom_range(max_pat, 1);
    tlen  = $urandom_range(max_txt, 1);
    alpha = $urandom_range(3, 1);
    add(OP_CLEAR, 8'($urandom));
    for (int i = 0; i < plen; i++) begin
      pat.push_back(8'($urandom_range(alpha - 1) + 8'h61));
      add(OP_APPEND, pat[i]);
    end
    for (int i = 0; i < tlen; i++) begin
      if ($urandom_range(99) < 25 && i + plen <= tlen) begin
        foreach (pat[k]) add(OP_TEXT, pat[k]);
        i += plen - 1;
      end else begin
        add(OP_TEXT, 8'($urandom_range(alpha - 1) + 8'h61));
      end
    end
    if ($urandom_range(3) == 0) add(OP_TEXT, 8'h00);
    if ($urandom_range(3) == 0) add(OP_APPEND, 8'($urandom));
  endtask

  task automatic drain;
    while (pending_beats.size() > 0 || expected_verdicts.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_stall_i    = 1'b0;
    opcode_i       = '0;
    byte_value_i   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b0;
    failed         = 1'b0;
    pat_len        = 0;
    txt_pos        = 0;
    srch_st        = ST_SEARCHING;
    hit_idx        = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: empty pattern, unused op, zero pattern byte, overlap, eot
    add(OP_TEXT, 8'h41);
    add(OP_TEXT, 8'h42);
    add(OP_NONE, 8'hff);
    add(OP_CLEAR, 8'h00);
    add(OP_APPEND, 8'h00);
    add(OP_APPEND, 8'h61);
    add(OP_APPEND, 8'h61);
    add(OP_APPEND, 8'h62);
    add(OP_TEXT, 8'h61);
    add(OP_TEXT, 8'h61);
    add(OP_APPEND, 8'h63);
    add(OP_TEXT, 8'h61);
    add(OP_TEXT, 8'h62);
    add(OP_TEXT, 8'h62);
    add(OP_NONE, 8'h00);
    add(OP_CLEAR, 8'hff);
    add(OP_APPEND, 8'hff);
    add(OP_TEXT, 8'h01);
    add(OP_TEXT, 8'h00);
    add(OP_TEXT, 8'hff);
    add(OP_CLEAR, 8'h55);
    add(OP_APPEND, 8'haa);
    add(OP_TEXT, 8'haa);
    drain();

    // full-length pattern, and text running past the window
    add(OP_CLEAR, 8'h00);
    for (int i = 0; i < MaxLen + 2; i++) add(OP_APPEND, 8'h77);
    for (int i = 0; i < MaxLen; i++) add(OP_TEXT, 8'h77);
    add(OP_CLEAR, 8'h00);
    add(OP_APPEND, 8'h01);
    for (int i = 0; i < MaxLen + 1; i++) add(OP_TEXT, 8'h02);
    add(OP_CLEAR, 8'h00);
    for (int i = 0; i < 3; i++) add(OP_APPEND, 8'h01);
    for (int i = 0; i < MaxLen - 1; i++) add(OP_TEXT, 8'h02);
    add(OP_TEXT, 8'h01);
    add(OP_TEXT, 8'h01);
    add(OP_TEXT, 8'h01);
    drain();

    // long receiver hold-off while the sender keeps offering
    for (int i = 0; i < 4; i++) add_search(4, 10);
    hold_go = 1'b1;
    wait (!hold_go);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? 78 : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? 78 : 0;
      if (ph == 3) begin
        send_idle_pct  = 11;
        recv_stall_pct = 11;
      end
      for (int n = 0; n < 12; n++) begin
        if ($urandom_range(9) == 0) begin
          add(opcode_e'($urandom_range(3)), 8'($urandom));
        end else begin
          add_search(6, 12);
        end
      end
      drain();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (20) @(posedge clk_i);
    if (failed) begin
      $display("first_substring_match_search test failed");
    end else begin
      $display("first_substring_match_search test passed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("first_substring_match_search test failed");
    $finish;
  end

endmodule
